// File: sv/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer.
// ============================================================================
package tcw_pkg;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_PUT_CHAR = 2'd0;
   localparam logic [1:0] REQ_SET_CURSOR = 2'd1;
   localparam logic [1:0] REQ_READ_CELL = 2'd2;

   // Character codes with a special meaning.
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_BLANK = 8'd32;

   // Register reset values.
   localparam logic [7:0] RESET_ATTR = 8'h0F;
   localparam logic [10:0] RESET_GUARD_CELLS = 11'd160;
   localparam logic [6:0] RESET_GUARD_COLUMNS = 7'd2;

   // Register map: register i sits at byte address 4*i.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_IDX_ATTR = 2'd0;
   localparam logic [1:0] CSR_IDX_GUARD_CELLS = 2'd1;
   localparam logic [1:0] CSR_IDX_GUARD_COLUMNS = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [10:0] position;
   } tcw_req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } tcw_rsp_type;

   // One store entry: attribute in the high byte, character in the low byte.
   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] chr;
   } tcw_cell_type;

endpackage

// File: sv/tcw_cell_ram.sv
// ============================================================================
// tcw_cell_ram
// Cell store: one write port and one read port with registered read data.
// ============================================================================
module tcw_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  tcw_pkg::tcw_cell_type wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output tcw_pkg::tcw_cell_type rd_data
);

   tcw_pkg::tcw_cell_type mem [DEPTH];
   tcw_pkg::tcw_cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tcw_col_div.sv
// ============================================================================
// tcw_col_div
// Column unit: finds the column of a cell index by reciprocal multiplication.
// ============================================================================
module tcw_col_div #(
   parameter int DIVISOR = 80,
   parameter int DIVIDEND_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_W-1:0]         dividend,
   output logic                          done,
   output logic [$clog2(DIVISOR)-1:0]    remainder
);

   localparam int REM_W = $clog2(DIVISOR);
   // The rounded-up reciprocal with REM_W extra fraction bits gives the exact
   // quotient for every dividend of DIVIDEND_W bits.
   localparam int SHIFT = DIVIDEND_W + REM_W;
   localparam int RECIP_W = DIVIDEND_W + 2;
   localparam int PROD_W = DIVIDEND_W + RECIP_W;
   localparam longint RECIP =
      ((longint'(1) <<< SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);

   logic                    done_ff, done_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [PROD_W-1:0]       product;
   logic [PROD_W-SHIFT-1:0] quotient;
   logic [DIVIDEND_W-1:0]   back;
   logic [DIVIDEND_W-1:0]   diff;

   assign product = PROD_W'(dividend) * PROD_W'(RECIP);
   assign quotient = product[PROD_W-1:SHIFT];
   assign back = DIVIDEND_W'(quotient) * DIVIDEND_W'(DIVISOR);
   assign diff = dividend - back;

   always_comb begin
      done_in = start;
      rem_in = rem_ff;
      if (start) begin
         rem_in = diff[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/text_console_writer_unit.sv
// ============================================================================
// text_console_writer_unit: text-mode console engine over a cell store
// Setting the cursor waits on the column remainder unit, which answers in
// the cycle after it starts; a request that scrolls sweeps every cell,
// paced by the cell memory's single read port.
// Reset clears the store in a pass over every cell; requests are held off.
// ============================================================================
//
// Organization
//   The character cells live in one synchronous memory (tcw_cell_ram) with
//   a registered read port. The cursor and its column are kept in registers
//   beside it, so put character never needs a division. Setting the cursor
//   to an arbitrary position runs the column remainder unit (tcw_col_div).
//
// Scrolling
//   When the cursor passes the last cell, a sweep walks every cell: it reads
//   the cell one row below and writes it back in the next cycle into the
//   current cell. The read of one address and the write of an address
//   COLUMNS + 1 below it never touch the same entry, so no forwarding is
//   needed. The bottom row is written with blanks in the configured
//   attribute.
//
// Output
//   A result sits in an output register until its transfer completes. The
//   next request is accepted while that result still waits; the block only
//   holds back when a further result is ready and the register is occupied.
//
module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  tcw_pkg::tcw_req_type            req_data,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tcw_pkg::tcw_rsp_type            rsp_data,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CUR_W = $clog2(CELLS);
   localparam int NXT_W = CUR_W + 1;
   localparam int COL_W = $clog2(COLUMNS);
   localparam int POS_W = 11;
   localparam int WIDE_W = (CUR_W > POS_W) ? CUR_W : POS_W;
   localparam int GK_W = (COL_W > 7) ? COL_W : 7;
   localparam int SCROLL_COPY = CELLS - COLUMNS;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_SCROLL = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   // Control and configuration state.
   state_type            state_ff, state_in;
   logic [CUR_W-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [CUR_W-1:0]     scan_ff, scan_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tcw_pkg::tcw_rsp_type rsp_data_ff, rsp_data_in;
   tcw_pkg::tcw_rsp_type res_ff, res_in;
   logic                 wb_valid_ff, wb_valid_in;
   logic [CUR_W-1:0]     wb_addr_ff, wb_addr_in;
   logic                 wb_blank_ff, wb_blank_in;
   logic                 div_pending_ff, div_pending_in;
   logic [7:0]           attr_ff;
   logic [10:0]          gcells_ff;
   logic [6:0]           gcols_ff;

   // Memory ports.
   logic                  mem_we;
   logic [CUR_W-1:0]      mem_waddr;
   tcw_pkg::tcw_cell_type mem_wdata;
   logic                  mem_re;
   logic [CUR_W-1:0]      mem_raddr;
   tcw_pkg::tcw_cell_type mem_rdata;

   // Column remainder unit.
   logic             div_start;
   logic             div_done;
   logic [COL_W-1:0] div_rem;

   // Put character decode.
   logic [NXT_W-1:0]      cur_ext;
   logic [NXT_W-1:0]      put_next;
   logic [COL_W-1:0]      put_col;
   logic                  put_we;
   logic [CUR_W-1:0]      put_waddr;
   tcw_pkg::tcw_cell_type put_wdata;
   logic                  put_wrap;
   logic                  bs_ok;
   logic [WIDE_W-1:0]     pos_wide;
   logic [CUR_W-1:0]      pos_clamped;
   logic [NXT_W-1:0]      scan_up;
   logic                  csr_write;

   // The cursor is reported in the 11-bit result field.
   function automatic logic [POS_W-1:0] to_pos(input logic [CUR_W-1:0] c);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(c);
      return w[POS_W-1:0];
   endfunction

   tcw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (CUR_W)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tcw_col_div #(
      .DIVISOR    (COLUMNS),
      .DIVIDEND_W (CUR_W)
   ) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cursor_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // ---------------------------------------------------------------------
   // Configuration port. Writes land on the access phase; reads are
   // answered from the same decode.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         tcw_pkg::CSR_IDX_ATTR:          csr_prdata = 32'(attr_ff);
         tcw_pkg::CSR_IDX_GUARD_CELLS:   csr_prdata = 32'(gcells_ff);
         tcw_pkg::CSR_IDX_GUARD_COLUMNS: csr_prdata = 32'(gcols_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::RESET_ATTR;
         gcells_ff <= tcw_pkg::RESET_GUARD_CELLS;
         gcols_ff <= tcw_pkg::RESET_GUARD_COLUMNS;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            tcw_pkg::CSR_IDX_ATTR:          attr_ff <= csr_pwdata[7:0];
            tcw_pkg::CSR_IDX_GUARD_CELLS:   gcells_ff <= csr_pwdata[10:0];
            tcw_pkg::CSR_IDX_GUARD_COLUMNS: gcols_ff <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request decode. Positions beyond the last cell are clamped to it.
   // ---------------------------------------------------------------------
   assign pos_wide = WIDE_W'(req_data.position);
   assign pos_clamped = (pos_wide >= WIDE_W'(CELLS)) ? CUR_W'(CELLS - 1)
                                                     : pos_wide[CUR_W-1:0];

   assign cur_ext = NXT_W'(cursor_ff);

   // Backspace only acts past both the cell guard and the column guard.
   assign bs_ok = (WIDE_W'(cursor_ff) > WIDE_W'(gcells_ff)) &&
                  (GK_W'(col_ff) > GK_W'(gcols_ff));

   always_comb begin
      put_next = cur_ext;
      put_col = col_ff;
      put_we = 1'b0;
      put_waddr = cursor_ff;
      put_wdata = '{attr: attr_ff, chr: req_data.char_code};
      if (req_data.char_code == tcw_pkg::CHAR_NEWLINE) begin
         put_next = cur_ext + NXT_W'(COLUMNS) - NXT_W'(col_ff);
         put_col = '0;
      end else if (req_data.char_code == tcw_pkg::CHAR_BACKSPACE) begin
         if (bs_ok) begin
            put_next = cur_ext - NXT_W'(1);
            put_col = col_ff - COL_W'(1);
            put_we = 1'b1;
            put_waddr = put_next[CUR_W-1:0];
            put_wdata = '{attr: attr_ff, chr: tcw_pkg::CHAR_BLANK};
         end
      end else begin
         put_next = cur_ext + NXT_W'(1);
         put_col = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
         put_we = 1'b1;
      end
   end

   // Passing the last cell always lands exactly on CELLS.
   assign put_wrap = (put_next >= NXT_W'(CELLS));

   // Scroll sweep reads one row below the cell it writes.
   assign scan_up = NXT_W'(scan_ff) + NXT_W'(COLUMNS);

   // The block takes a request only when idle, once the previous one has handed its result to the output register.
   assign req_ready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cursor_in = cursor_ff;
      col_in = col_ff;
      scan_in = scan_ff;
      res_in = res_ff;
      wb_valid_in = 1'b0;
      wb_addr_in = scan_ff;
      wb_blank_in = 1'b0;
      mem_re = 1'b0;
      mem_raddr = pos_clamped;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      // The write-back half of the scroll sweep owns the write port
      // whenever it holds a cell; no other state writes at that time.
      mem_we = wb_valid_ff;
      mem_waddr = wb_addr_ff;
      mem_wdata = mem_rdata;
      if (wb_blank_ff) begin
         mem_wdata = '{attr: attr_ff, chr: tcw_pkg::CHAR_BLANK};
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = '{attr: tcw_pkg::RESET_ATTR, chr: tcw_pkg::CHAR_BLANK};
            scan_in = scan_ff + CUR_W'(1);
            if (scan_ff == CUR_W'(CELLS - 1)) begin
               scan_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '{cursor_position: to_pos(cursor_ff), cell_char: '0, cell_attr: '0};
               case (req_data.req_type)
                  tcw_pkg::REQ_PUT_CHAR: begin
                     mem_we = put_we;
                     mem_waddr = put_waddr;
                     mem_wdata = put_wdata;
                     if (put_wrap) begin
                        cursor_in = CUR_W'(CELLS - COLUMNS);
                        col_in = '0;
                        scan_in = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        cursor_in = put_next[CUR_W-1:0];
                        col_in = put_col;
                        state_in = ST_RESP;
                     end
                     res_in.cursor_position = to_pos(cursor_in);
                  end
                  tcw_pkg::REQ_SET_CURSOR: begin
                     cursor_in = pos_clamped;
                     state_in = ST_DIV;
                     res_in.cursor_position = to_pos(pos_clamped);
                  end
                  tcw_pkg::REQ_READ_CELL: begin
                     mem_re = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in.cell_char = mem_rdata.chr;
            res_in.cell_attr = mem_rdata.attr;
            state_in = ST_RESP;
         end
         ST_DIV: begin
            if (div_done) begin
               col_in = div_rem;
               state_in = ST_RESP;
            end
         end
         ST_SCROLL: begin
            mem_re = (scan_ff < CUR_W'(SCROLL_COPY));
            mem_raddr = scan_up[CUR_W-1:0];
            wb_valid_in = 1'b1;
            wb_addr_in = scan_ff;
            wb_blank_in = (scan_ff >= CUR_W'(SCROLL_COPY));
            scan_in = scan_ff + CUR_W'(1);
            if (scan_ff == CUR_W'(CELLS - 1)) begin
               scan_in = '0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The divider starts on the cycle after the cursor register takes the
   // clamped position, so its operand is already the new cursor.
   assign div_pending_in = (state_ff == ST_IDLE) && req_valid &&
                           (req_data.req_type == tcw_pkg::REQ_SET_CURSOR);
   assign div_start = div_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cursor_ff <= '0;
         col_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         div_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cursor_ff <= cursor_in;
         col_ff <= col_in;
         scan_ff <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_valid_ff <= wb_valid_in;
         div_pending_ff <= div_pending_in;
      end
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
      wb_addr_ff <= wb_addr_in;
      wb_blank_ff <= wb_blank_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff < CUR_W'(CELLS))
      else $error("cursor beyond the last cell");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < COL_W'(COLUMNS))
      else $error("column beyond the last column");

   a_wb_owner: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == ST_SCROLL || state_ff == ST_RESP))
      else $error("scroll write-back outside the sweep");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("column result arrived outside the set cursor wait");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !req_ready))
      else $error("traffic during the clearing pass");

endmodule
